@@ src/rau_pkg.sv @@
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int PW            = 2 * OPERAND_WIDTH;
    localparam int RES_W         = 33;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH + 1);
    localparam int KW            = $clog2(OPERAND_WIDTH);
    localparam int UA_W          = 5;

    typedef logic [UA_W-1:0] t_uaddr;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REDUCE, OP_INV, OP_CMP, OP_BAD
    } t_op;

    typedef enum logic [1:0] {
        CMP_LT = 2'd0,
        CMP_EQ = 2'd1,
        CMP_GT = 2'd2
    } t_cmp;

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    typedef enum logic [2:0] {
        MUL_NONE, MUL_AN_BD, MUL_AD_BN, MUL_AN_BN, MUL_AD_BD
    } t_mul_sel;

    typedef enum logic {DST_P0, DST_P1} t_mul_dst;

    typedef enum logic [2:0] {
        NUM_HOLD, NUM_ADD, NUM_SUB, NUM_P0, NUM_AN, NUM_AD, NUM_QUO, NUM_ZERO
    } t_num_op;

    typedef enum logic [2:0] {
        DEN_HOLD, DEN_P0, DEN_P1, DEN_AN, DEN_AD, DEN_QUO, DEN_ZERO
    } t_den_op;

    typedef enum logic [2:0] {
        SEQ_NONE, SEQ_GCD_INIT, SEQ_GCD_STEP, SEQ_DIV_NUM, SEQ_DIV_DEN, SEQ_DIV_STEP
    } t_seq_op;

    typedef enum logic [1:0] {
        JMP_NEXT, JMP_GCD_BUSY, JMP_DIV_BUSY, JMP_ZERO_PART
    } t_jump;

    typedef struct packed {
        t_mul_sel mul;
        t_mul_dst dst;
        t_num_op  num;
        t_den_op  den;
        logic     cmp_set;
        t_seq_op  seq;
        t_jump    jump;
        t_uaddr   target;
        logic     fin;
    } t_uword;

    // Program entry points and loop addresses.
    localparam t_uaddr UA_ADD      = 5'd0;
    localparam t_uaddr UA_SUB      = 5'd4;
    localparam t_uaddr UA_MUL      = 5'd8;
    localparam t_uaddr UA_DIV      = 5'd11;
    localparam t_uaddr UA_REDUCE   = 5'd14;
    localparam t_uaddr UA_GCD_LOOP = 5'd15;
    localparam t_uaddr UA_DIVN     = 5'd16;
    localparam t_uaddr UA_DIVN_LP  = 5'd17;
    localparam t_uaddr UA_DIVD     = 5'd18;
    localparam t_uaddr UA_DIVD_LP  = 5'd19;
    localparam t_uaddr UA_RED_END  = 5'd20;
    localparam t_uaddr UA_RED_ONE  = 5'd21;
    localparam t_uaddr UA_INV      = 5'd22;
    localparam t_uaddr UA_CMP      = 5'd23;
    localparam t_uaddr UA_BAD      = 5'd26;

    function automatic t_uword mk(t_mul_sel mul, t_mul_dst dst, t_num_op num,
                                  t_den_op den, logic cs, t_seq_op seq,
                                  t_jump jmp, t_uaddr tgt, logic fin);
        t_uword w;
        w.mul     = mul;
        w.dst     = dst;
        w.num     = num;
        w.den     = den;
        w.cmp_set = cs;
        w.seq     = seq;
        w.jump    = jmp;
        w.target  = tgt;
        w.fin     = fin;
        return w;
    endfunction

    function automatic t_uaddr entry(t_op op);
        t_uaddr a;
        unique case (op)
            OP_ADD:    a = UA_ADD;
            OP_SUB:    a = UA_SUB;
            OP_MUL:    a = UA_MUL;
            OP_DIV:    a = UA_DIV;
            OP_REDUCE: a = UA_REDUCE;
            OP_INV:    a = UA_INV;
            OP_CMP:    a = UA_CMP;
            default:   a = UA_BAD;
        endcase
        return a;
    endfunction

    // Microcode store: one control word per step.
    function automatic t_uword ucode(t_uaddr a);
        t_uword w;
        unique case (a)
            5'd0:  w = mk(MUL_AN_BD, DST_P0, NUM_HOLD, DEN_HOLD, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_ADD, 1'b0);
            5'd1:  w = mk(MUL_AD_BN, DST_P1, NUM_HOLD, DEN_HOLD, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_ADD, 1'b0);
            5'd2:  w = mk(MUL_AD_BD, DST_P0, NUM_ADD, DEN_HOLD, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_ADD, 1'b0);
            5'd3:  w = mk(MUL_NONE, DST_P0, NUM_HOLD, DEN_P0, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_ADD, 1'b1);
            5'd4:  w = mk(MUL_AN_BD, DST_P0, NUM_HOLD, DEN_HOLD, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_SUB, 1'b0);
            5'd5:  w = mk(MUL_AD_BN, DST_P1, NUM_HOLD, DEN_HOLD, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_SUB, 1'b0);
            5'd6:  w = mk(MUL_AD_BD, DST_P0, NUM_SUB, DEN_HOLD, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_SUB, 1'b0);
            5'd7:  w = mk(MUL_NONE, DST_P0, NUM_HOLD, DEN_P0, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_SUB, 1'b1);
            5'd8:  w = mk(MUL_AN_BN, DST_P0, NUM_HOLD, DEN_HOLD, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_MUL, 1'b0);
            5'd9:  w = mk(MUL_AD_BD, DST_P1, NUM_HOLD, DEN_HOLD, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_MUL, 1'b0);
            5'd10: w = mk(MUL_NONE, DST_P0, NUM_P0, DEN_P1, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_MUL, 1'b1);
            5'd11: w = mk(MUL_AN_BD, DST_P0, NUM_HOLD, DEN_HOLD, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_DIV, 1'b0);
            5'd12: w = mk(MUL_AD_BN, DST_P1, NUM_HOLD, DEN_HOLD, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_DIV, 1'b0);
            5'd13: w = mk(MUL_NONE, DST_P0, NUM_P0, DEN_P1, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_DIV, 1'b1);
            5'd14: w = mk(MUL_NONE, DST_P0, NUM_HOLD, DEN_HOLD, 1'b0, SEQ_GCD_INIT,
                          JMP_ZERO_PART, UA_RED_ONE, 1'b0);
            5'd15: w = mk(MUL_NONE, DST_P0, NUM_HOLD, DEN_HOLD, 1'b0, SEQ_GCD_STEP,
                          JMP_GCD_BUSY, UA_GCD_LOOP, 1'b0);
            5'd16: w = mk(MUL_NONE, DST_P0, NUM_HOLD, DEN_HOLD, 1'b0, SEQ_DIV_NUM,
                          JMP_NEXT, UA_DIVN, 1'b0);
            5'd17: w = mk(MUL_NONE, DST_P0, NUM_HOLD, DEN_HOLD, 1'b0, SEQ_DIV_STEP,
                          JMP_DIV_BUSY, UA_DIVN_LP, 1'b0);
            5'd18: w = mk(MUL_NONE, DST_P0, NUM_QUO, DEN_HOLD, 1'b0, SEQ_DIV_DEN,
                          JMP_NEXT, UA_DIVD, 1'b0);
            5'd19: w = mk(MUL_NONE, DST_P0, NUM_HOLD, DEN_HOLD, 1'b0, SEQ_DIV_STEP,
                          JMP_DIV_BUSY, UA_DIVD_LP, 1'b0);
            5'd20: w = mk(MUL_NONE, DST_P0, NUM_HOLD, DEN_QUO, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_RED_END, 1'b1);
            5'd21: w = mk(MUL_NONE, DST_P0, NUM_AN, DEN_AD, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_RED_ONE, 1'b1);
            5'd22: w = mk(MUL_NONE, DST_P0, NUM_AD, DEN_AN, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_INV, 1'b1);
            5'd23: w = mk(MUL_AN_BD, DST_P0, NUM_HOLD, DEN_HOLD, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_CMP, 1'b0);
            5'd24: w = mk(MUL_AD_BN, DST_P1, NUM_HOLD, DEN_HOLD, 1'b0, SEQ_NONE,
                          JMP_NEXT, UA_CMP, 1'b0);
            5'd25: w = mk(MUL_NONE, DST_P0, NUM_AN, DEN_AD, 1'b1, SEQ_NONE,
                          JMP_NEXT, UA_CMP, 1'b1);
            default: w = mk(MUL_NONE, DST_P0, NUM_ZERO, DEN_ZERO, 1'b0, SEQ_NONE,
                            JMP_NEXT, UA_BAD, 1'b1);
        endcase
        return w;
    endfunction

    function automatic logic [OPERAND_WIDTH-1:0] mag(logic signed [OPERAND_WIDTH-1:0] v);
        return v[OPERAND_WIDTH-1] ? OPERAND_WIDTH'(-v) : OPERAND_WIDTH'(v);
    endfunction

endpackage

@@ src/rational_arithmetic_unit.sv @@
// Programs: add, subtract, multiply, divide, compare, inverse and an undefined code run fixed
// step sequences; reduce with a zero part skips to its final step, otherwise it runs the binary
// GCD loop and two divider loops; o_valid rises the cycle after the last step.
// o_stall is held from acceptance until the result is registered, so no new item is taken
// until the last one is through; a result still waiting at the output holds the last step.
// Reset (i_rst_n, synchronous, active low) idles the sequencer and empties the output.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [2:0]                      i_req_type,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_a_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_b_den,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [RES_W-1:0]         o_res_num,
    output logic signed [RES_W-1:0]         o_res_den,
    output logic [1:0]                      o_cmp_result
);

    t_state r_state, n_state;
    t_uaddr r_upc, n_upc;
    t_uword uw;

    logic signed [OPERAND_WIDTH-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [PW-1:0]            r_p0, n_p0, r_p1, n_p1;
    logic signed [RES_W-1:0]         r_num, n_num, r_den, n_den;
    t_cmp                            r_cmp, n_cmp;

    logic [OPERAND_WIDTH-1:0] r_gx, n_gx, r_gy, n_gy;
    logic [KW-1:0]            r_gk, n_gk;
    logic [OPERAND_WIDTH-1:0] r_dvs, n_dvs, r_rem, n_rem, r_quo, n_quo;
    logic [CNT_W-1:0]         r_dcnt, n_dcnt;

    logic signed [RES_W-1:0] r_o_num, r_o_den;
    t_cmp                    r_o_cmp;
    logic                    r_o_valid, n_o_valid;

    logic                    accept, run, load_out;
    logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
    logic signed [PW-1:0]    prod, left, right;
    logic [OPERAND_WIDTH-1:0] gcd;
    logic [OPERAND_WIDTH:0]  rem_sh;
    logic [OPERAND_WIDTH+1:0] trial;
    logic signed [RES_W-1:0] quo_ext;
    logic                    gcd_busy, div_busy, zero_part, jump_taken;

    assign uw        = ucode(r_upc);
    assign gcd_busy  = (r_gx != r_gy);
    assign div_busy  = (r_dcnt != CNT_W'(OPERAND_WIDTH));
    assign zero_part = (r_an == '0) || (r_ad == '0);

    // FSM outputs.
    always_comb begin
        o_stall = (r_state != ST_IDLE);
        run     = (r_state == ST_RUN);
    end

    assign accept   = i_valid && !o_stall;
    assign load_out = run && uw.fin && (!r_o_valid || !i_stall);

    always_comb begin
        unique case (uw.jump)
            JMP_GCD_BUSY:  jump_taken = gcd_busy;
            JMP_DIV_BUSY:  jump_taken = div_busy;
            JMP_ZERO_PART: jump_taken = zero_part;
            default:       jump_taken = 1'b0;
        endcase
    end

    // FSM next state and step counter.
    always_comb begin
        n_state = r_state;
        n_upc   = r_upc;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_RUN;
                    n_upc   = entry(t_op'(i_req_type));
                end
            end
            default: begin
                if (uw.fin) begin
                    if (load_out) begin
                        n_state = ST_IDLE;
                    end
                end else if (jump_taken) begin
                    n_upc = uw.target;
                end else begin
                    n_upc = r_upc + 1'b1;
                end
            end
        endcase
    end

    // Shared multiplier.
    always_comb begin
        unique case (uw.mul)
            MUL_AN_BD: begin mul_a = r_an; mul_b = r_bd; end
            MUL_AD_BN: begin mul_a = r_ad; mul_b = r_bn; end
            MUL_AN_BN: begin mul_a = r_an; mul_b = r_bn; end
            MUL_AD_BD: begin mul_a = r_ad; mul_b = r_bd; end
            default:   begin mul_a = '0;   mul_b = '0;   end
        endcase
        prod = mul_a * mul_b;
    end

    always_comb begin
        n_p0 = r_p0;
        n_p1 = r_p1;
        if (run && uw.mul != MUL_NONE) begin
            if (uw.dst == DST_P0) begin
                n_p0 = prod;
            end else begin
                n_p1 = prod;
            end
        end
    end

    // Result fraction and comparison.
    always_comb begin
        quo_ext = RES_W'(r_quo);
        left    = (r_ad == r_bd) ? PW'(r_an) : r_p0;
        right   = (r_ad == r_bd) ? PW'(r_bn) : r_p1;

        unique case (uw.num)
            NUM_ADD:  n_num = RES_W'(r_p0) + RES_W'(r_p1);
            NUM_SUB:  n_num = RES_W'(r_p0) - RES_W'(r_p1);
            NUM_P0:   n_num = RES_W'(r_p0);
            NUM_AN:   n_num = RES_W'(r_an);
            NUM_AD:   n_num = RES_W'(r_ad);
            NUM_QUO:  n_num = r_an[OPERAND_WIDTH-1] ? -quo_ext : quo_ext;
            NUM_ZERO: n_num = '0;
            default:  n_num = r_num;
        endcase

        unique case (uw.den)
            DEN_P0:   n_den = RES_W'(r_p0);
            DEN_P1:   n_den = RES_W'(r_p1);
            DEN_AN:   n_den = RES_W'(r_an);
            DEN_AD:   n_den = RES_W'(r_ad);
            DEN_QUO:  n_den = r_ad[OPERAND_WIDTH-1] ? -quo_ext : quo_ext;
            DEN_ZERO: n_den = '0;
            default:  n_den = r_den;
        endcase

        if (accept) begin
            n_cmp = CMP_EQ;
        end else if (run && uw.cmp_set) begin
            if (left > right) begin
                n_cmp = CMP_GT;
            end else if (left < right) begin
                n_cmp = CMP_LT;
            end else begin
                n_cmp = CMP_EQ;
            end
        end else begin
            n_cmp = r_cmp;
        end
    end

    // Binary GCD over the magnitudes and restoring divider, one step a cycle.
    always_comb begin
        n_gx   = r_gx;
        n_gy   = r_gy;
        n_gk   = r_gk;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dcnt = r_dcnt;
        gcd    = r_gx << r_gk;
        rem_sh = {r_rem, r_quo[OPERAND_WIDTH-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r_dvs};

        if (run) begin
            unique case (uw.seq)
                SEQ_GCD_INIT: begin
                    n_gx = mag(r_an);
                    n_gy = mag(r_ad);
                    n_gk = '0;
                end
                SEQ_GCD_STEP: begin
                    // The loop row repeats until both values meet; no step once equal.
                    if (gcd_busy) begin
                        priority if (!r_gx[0] && !r_gy[0]) begin
                            n_gx = r_gx >> 1;
                            n_gy = r_gy >> 1;
                            n_gk = r_gk + 1'b1;
                        end else if (!r_gx[0]) begin
                            n_gx = r_gx >> 1;
                        end else if (!r_gy[0]) begin
                            n_gy = r_gy >> 1;
                        end else if (r_gx > r_gy) begin
                            n_gx = (r_gx - r_gy) >> 1;
                        end else begin
                            n_gy = (r_gy - r_gx) >> 1;
                        end
                    end
                end
                SEQ_DIV_NUM: begin
                    n_dvs  = gcd;
                    n_rem  = '0;
                    n_quo  = mag(r_an);
                    n_dcnt = '0;
                end
                SEQ_DIV_DEN: begin
                    n_rem  = '0;
                    n_quo  = mag(r_ad);
                    n_dcnt = '0;
                end
                SEQ_DIV_STEP: begin
                    if (div_busy) begin
                        n_dcnt = r_dcnt + 1'b1;
                        if (!trial[OPERAND_WIDTH+1]) begin
                            n_rem = trial[OPERAND_WIDTH-1:0];
                            n_quo = {r_quo[OPERAND_WIDTH-2:0], 1'b1};
                        end else begin
                            n_rem = rem_sh[OPERAND_WIDTH-1:0];
                            n_quo = {r_quo[OPERAND_WIDTH-2:0], 1'b0};
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (load_out) begin
            n_o_valid = 1'b1;
        end else if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_upc     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_upc     <= n_upc;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_an <= i_a_num;
            r_ad <= i_a_den;
            r_bn <= i_b_num;
            r_bd <= i_b_den;
        end
        if (run) begin
            r_num <= n_num;
            r_den <= n_den;
        end
        r_cmp  <= n_cmp;
        r_p0   <= n_p0;
        r_p1   <= n_p1;
        r_gx   <= n_gx;
        r_gy   <= n_gy;
        r_gk   <= n_gk;
        r_dvs  <= n_dvs;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dcnt <= n_dcnt;
        if (load_out) begin
            r_o_num <= n_num;
            r_o_den <= n_den;
            r_o_cmp <= n_cmp;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_res_num    = r_o_num;
    assign o_res_den    = r_o_den;
    assign o_cmp_result = r_o_cmp;

endmodule

@@ dv/rational_arithmetic_unit_tb.sv @@
module rational_arithmetic_unit_tb
    import rau_pkg::*;
();

    localparam int NUM_RANDOM  = 930;
    localparam int QUIET_FROM  = 820;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 200;

    typedef logic signed [OPERAND_WIDTH-1:0] t_part;
    typedef logic signed [RES_W-1:0]         t_wide;

    typedef struct packed {
        t_wide num;
        t_wide den;
        t_cmp  cmp;
    } t_frac_res;

    typedef struct packed {
        t_op   op;
        t_part a_num;
        t_part a_den;
        t_part b_num;
        t_part b_den;
        logic  typed;
        t_wide num;
        t_wide den;
        t_cmp  cmp;
    } t_stim_row;

    // Rows with typed = 1 carry their expected result; the rest go through the predictor.
    localparam int NUM_DIRECTED = 23;
    localparam t_stim_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{OP_ADD, 1, 2, 1, 3, 1'b0, 0, 0, CMP_EQ},
        '{OP_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1,
          33'sd2147483648, 33'sd1073741824, CMP_EQ},
        '{OP_ADD, 1, 0, 1, 0, 1'b1, 0, 0, CMP_EQ},
        '{OP_SUB, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b0, 0, 0, CMP_EQ},
        '{OP_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0, 0, 0, CMP_EQ},
        '{OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1,
          33'sd1073741824, 33'sd1073741824, CMP_EQ},
        '{OP_MUL, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0, 0, 0, CMP_EQ},
        '{OP_DIV, 3, 4, 0, 5, 1'b1, 15, 0, CMP_EQ},
        '{OP_DIV, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b0, 0, 0, CMP_EQ},
        '{OP_REDUCE, 0, 7, 5, 5, 1'b1, 0, 7, CMP_EQ},
        '{OP_REDUCE, 9, 0, 5, 5, 1'b1, 9, 0, CMP_EQ},
        '{OP_REDUCE, 6, -4, 0, 0, 1'b1, 3, -2, CMP_EQ},
        '{OP_REDUCE, -12, -18, 0, 0, 1'b1, -2, -3, CMP_EQ},
        '{OP_REDUCE, 16'sh8000, 16'sh8000, 0, 0, 1'b1, -1, -1, CMP_EQ},
        '{OP_REDUCE, 16'sh7fff, 16'sh7fff, 0, 0, 1'b1, 1, 1, CMP_EQ},
        '{OP_REDUCE, 16'sh8000, 16'sh7fff, 0, 0, 1'b0, 0, 0, CMP_EQ},
        '{OP_INV, 16'sh8000, 16'sh7fff, 0, 0, 1'b1, 32767, -32768, CMP_EQ},
        '{OP_CMP, 1, 3, 2, 3, 1'b1, 1, 3, CMP_LT},
        '{OP_CMP, 5, 7, 5, 7, 1'b1, 5, 7, CMP_EQ},
        '{OP_CMP, 1, -2, 1, 3, 1'b1, 1, -2, CMP_GT},
        '{OP_CMP, 2, 4, 1, 2, 1'b1, 2, 4, CMP_EQ},
        '{OP_CMP, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b0, 0, 0, CMP_EQ},
        '{OP_BAD, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b1, 0, 0, CMP_EQ}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_req_type;
    t_part       i_a_num;
    t_part       i_a_den;
    t_part       i_b_num;
    t_part       i_b_den;
    logic        o_valid;
    logic        i_stall;
    t_wide       o_res_num;
    t_wide       o_res_den;
    logic [1:0]  o_cmp_result;

    t_frac_res   pending_results [$];
    int          fail_count;
    int          cycle_count;
    logic        quiet_tail;

    rational_arithmetic_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_a_num      (i_a_num),
        .i_a_den      (i_a_den),
        .i_b_num      (i_b_num),
        .i_b_den      (i_b_den),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_res_num    (o_res_num),
        .o_res_den    (o_res_den),
        .o_cmp_result (o_cmp_result)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic t_frac_res rational_result(t_op op, t_part an, t_part ad,
                                                  t_part bn, t_part bd);
        t_frac_res          r;
        logic signed [63:0] an64, ad64, bn64, bd64, lhs, rhs, qn, qd;
        logic [63:0]        mag_n, mag_d, x, y, t, g;
        an64 = an;
        ad64 = ad;
        bn64 = bn;
        bd64 = bd;
        r.num = '0;
        r.den = '0;
        r.cmp = CMP_EQ;
        case (op)
            OP_ADD: begin
                r.num = RES_W'(an64 * bd64 + ad64 * bn64);
                r.den = RES_W'(ad64 * bd64);
            end
            OP_SUB: begin
                r.num = RES_W'(an64 * bd64 - ad64 * bn64);
                r.den = RES_W'(ad64 * bd64);
            end
            OP_MUL: begin
                r.num = RES_W'(an64 * bn64);
                r.den = RES_W'(ad64 * bd64);
            end
            OP_DIV: begin
                r.num = RES_W'(an64 * bd64);
                r.den = RES_W'(ad64 * bn64);
            end
            OP_REDUCE: begin
                mag_n = (an64 < 0) ? -an64 : an64;
                mag_d = (ad64 < 0) ? -ad64 : ad64;
                g = 64'd1;
                // A zero part leaves the fraction as it is.
                if (an != 0 && ad != 0) begin
                    x = mag_n;
                    y = mag_d;
                    while (y != 0) begin
                        t = x % y;
                        x = y;
                        y = t;
                    end
                    g = x;
                end
                qn = $signed(mag_n / g);
                qd = $signed(mag_d / g);
                r.num = RES_W'((an64 < 0) ? -qn : qn);
                r.den = RES_W'((ad64 < 0) ? -qd : qd);
            end
            OP_INV: begin
                r.num = RES_W'(ad64);
                r.den = RES_W'(an64);
            end
            OP_CMP: begin
                // Numerators on equal denominators, else cross products, as they stand.
                if (ad == bd) begin
                    lhs = an64;
                    rhs = bn64;
                end else begin
                    lhs = an64 * bd64;
                    rhs = bn64 * ad64;
                end
                r.cmp = (lhs > rhs) ? CMP_GT : ((lhs < rhs) ? CMP_LT : CMP_EQ);
                r.num = RES_W'(an64);
                r.den = RES_W'(ad64);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_part rand_part();
        int sel;
        t_part v;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3: v = OPERAND_WIDTH'($urandom);
            4, 5, 6:    v = OPERAND_WIDTH'($urandom_range(0, 128) - 64);
            7: begin
                case ($urandom_range(0, 4))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7fff;
                    2:       v = -1;
                    3:       v = 1;
                    default: v = 0;
                endcase
            end
            default:    v = OPERAND_WIDTH'($urandom_range(0, 2000) - 1000);
        endcase
        return v;
    endfunction

    task automatic send_item(t_op op, t_part an, t_part ad, t_part bn, t_part bd,
                             t_frac_res want);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= op;
        i_a_num    <= an;
        i_a_den    <= ad;
        i_b_num    <= bn;
        i_b_den    <= bd;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(want);
    endtask

    // Receiver back-pressure in bursts, switched off for the tail of the run.
    initial begin
        int run;
        i_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            if (quiet_tail) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                run = $urandom_range(1, 12);
                i_stall <= ($urandom_range(0, 2) == 0);
                repeat (run) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_frac_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no item outstanding: num %0d den %0d cmp %0d",
                       o_res_num, o_res_den, o_cmp_result);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_res_num !== want.num) begin
                    $error("res_num: expected %0d, got %0d", want.num, o_res_num);
                    fail_count++;
                end
                if (o_res_den !== want.den) begin
                    $error("res_den: expected %0d, got %0d", want.den, o_res_den);
                    fail_count++;
                end
                if (o_cmp_result !== want.cmp) begin
                    $error("cmp_result: expected %0d, got %0d", want.cmp, o_cmp_result);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_stim_row row;
        t_frac_res want;
        t_op       op;
        t_part     an, ad, bn, bd;
        int        pick;
        fail_count  = 0;
        cycle_count = 0;
        quiet_tail  = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req_type  = '0;
        i_a_num     = '0;
        i_a_den     = '0;
        i_b_num     = '0;
        i_b_den     = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_ROWS[k]) begin
            row = DIRECTED_ROWS[k];
            if (row.typed)
                want = '{row.num, row.den, row.cmp};
            else
                want = rational_result(row.op, row.a_num, row.a_den, row.b_num, row.b_den);
            send_item(row.op, row.a_num, row.a_den, row.b_num, row.b_den, want);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == QUIET_FROM)
                quiet_tail = 1'b1;
            pick = $urandom_range(0, 99);
            op = (pick < 4) ? OP_BAD : t_op'(pick % 7);
            an = rand_part();
            ad = rand_part();
            bn = rand_part();
            bd = rand_part();
            // Give reduce a shared factor half of the time so the GCD is not trivial.
            if (op == OP_REDUCE && $urandom_range(0, 1) == 0) begin
                pick = $urandom_range(1, 180);
                an = OPERAND_WIDTH'(pick * ($urandom_range(0, 360) - 180));
                ad = OPERAND_WIDTH'(pick * ($urandom_range(0, 360) - 180));
            end
            if (op == OP_CMP) begin
                case ($urandom_range(0, 5))
                    0, 1: bd = ad;
                    2: begin
                        bn = an;
                        bd = ad;
                    end
                    default: begin
                    end
                endcase
            end
            send_item(op, an, ad, bn, bd, rational_result(op, an, ad, bn, bd));
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
